// File: rtl/bts_pkg.sv
// Shared types and constants for the board tag stream scanner.
// No dependencies.
package bts_pkg;

  localparam int unsigned MAGIC_CHARS = 20;
  localparam int unsigned MPOS_W     = 5;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned NAME_W     = 64;
  localparam logic [7:0]  TERM_BYTE  = 8'h3B;
  localparam logic [7:0]  PRINT_LOW  = 8'h20;
  localparam logic [7:0]  PRINT_HIGH = 8'h7F;

  // configuration register indexes
  localparam logic CFG_EXP_NAME = 1'b0;
  localparam logic CFG_EXP_LEN  = 1'b1;

  typedef struct packed {
    logic in_capture;
    logic mismatch;
  } bts_result_t;

  // 20-character tag magic, one character per position
  function automatic logic [7:0] magic_byte(input logic [MPOS_W-1:0] pos);
    logic [7:0] b;
    case (pos)
      5'd0:    b = 8'h43;
      5'd1:    b = 8'h52;
      5'd2:    b = 8'h4F;
      5'd3:    b = 8'h53;
      5'd4:    b = 8'h53;
      5'd5:    b = 8'h50;
      5'd6:    b = 8'h4F;
      5'd7:    b = 8'h49;
      5'd8:    b = 8'h4E;
      5'd9:    b = 8'h54;
      5'd10:   b = 8'h2D;
      5'd11:   b = 8'h42;
      5'd12:   b = 8'h4F;
      5'd13:   b = 8'h41;
      5'd14:   b = 8'h52;
      5'd15:   b = 8'h44;
      5'd16:   b = 8'h2D;
      5'd17:   b = 8'h56;
      5'd18:   b = 8'h31;
      5'd19:   b = 8'h3A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/bts_scan_core.sv
// Scan state of the board tag scanner: magic matcher, name capture, name compare.
// Depends on bts_pkg.
module bts_scan_core import bts_pkg::*; #(
  parameter int unsigned NAME_MAX = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic [NAME_W-1:0] expected_name,
  input  logic [LEN_W-1:0]  expected_len,
  output bts_result_t       result
);

  localparam int unsigned CNT_W = $clog2(NAME_MAX + 1);
  localparam int unsigned IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(NAME_MAX);
  localparam logic [CNT_W-1:0] IDX_MASK = CNT_W'(NAME_MAX - 1);
  localparam logic [MPOS_W-1:0] MPOS_END = MPOS_W'(MAGIC_CHARS);

  logic [MPOS_W-1:0] magic_pos_r, magic_pos_nxt;
  logic              capture_r, capture_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              mismatch_r, mismatch_nxt;
  logic [7:0]        store_r [NAME_MAX];
  logic              store_we;
  logic [IDX_W-1:0]  store_idx;

  logic [MPOS_W-1:0] pos_eff;
  logic              printable;
  logic              name_ok;
  logic [NAME_MAX-1:0] lane_ok;

  assign printable = (data_byte > PRINT_LOW) && (data_byte < PRINT_HIGH);
  assign pos_eff   = (magic_pos_r >= MPOS_END) ? '0 : magic_pos_r;
  assign store_idx = IDX_W'(count_r & IDX_MASK);

  // one compare lane per stored character; lanes past the count don't care
  always_comb begin
    for (int i = 0; i < NAME_MAX; i++) begin
      lane_ok[i] = (CNT_W'(i) >= count_r) || (store_r[i] == expected_name[8*i +: 8]);
    end
  end

  assign name_ok = (LEN_W'(count_r) == expected_len) && (&lane_ok);

  always_comb begin
    magic_pos_nxt = magic_pos_r;
    capture_nxt   = capture_r;
    count_nxt     = count_r;
    mismatch_nxt  = mismatch_r;
    store_we      = 1'b0;
    if (!mismatch_r) begin
      if (capture_r) begin
        if (data_byte == TERM_BYTE) begin
          capture_nxt = 1'b0;
          if (!name_ok) mismatch_nxt = 1'b1;
        end else if ((count_r < CNT_MAX) && printable) begin
          store_we  = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          // abandoned capture; this byte is not fed to the matcher
          capture_nxt = 1'b0;
        end
      end else if (data_byte == magic_byte(pos_eff)) begin
        if (pos_eff == MPOS_END - 1'b1) begin
          magic_pos_nxt = '0;
          capture_nxt   = 1'b1;
          count_nxt     = '0;
        end else begin
          magic_pos_nxt = pos_eff + 1'b1;
        end
      end else begin
        // one-byte lookback: failing byte may start a new match
        magic_pos_nxt = (data_byte == magic_byte('0)) ? MPOS_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_pos_r <= '0;
      capture_r   <= 1'b0;
      count_r     <= '0;
      mismatch_r  <= 1'b0;
    end else if (step) begin
      magic_pos_r <= magic_pos_nxt;
      capture_r   <= capture_nxt;
      count_r     <= count_nxt;
      mismatch_r  <= mismatch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store_we) store_r[store_idx] <= data_byte;
  end

  assign result.mismatch   = mismatch_nxt;
  assign result.in_capture = capture_nxt;

endmodule

// File: rtl/board_tag_stream_scanner.sv
// Board tag stream scanner top level: stream ports, configuration registers,
// output register with skid stage. Depends on bts_pkg and bts_scan_core.

// Takes one image byte per transfer and returns one status transfer per byte
// through the result register, via the skid register while the output stalls.
// A new byte is accepted every cycle while the skid register is empty, and a
// two-entry output stage (result register plus skid register) lets one more
// byte in while a result waits. Configuration writes are always accepted and
// should be made only while no results are outstanding.
module board_tag_stream_scanner import bts_pkg::*; #(
  parameter int unsigned NAME_MAX = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [0] mismatch, [1] in_capture, [7:2] zero
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [NAME_W-1:0] cfg_data
);

  logic [NAME_W-1:0] exp_name_r;
  logic [LEN_W-1:0]  exp_len_r;
  logic              in_acc;
  logic              out_take;
  bts_result_t       res;
  logic              out_valid_r, skid_valid_r;
  bts_result_t       out_data_r, skid_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_name_r <= NAME_W'(64'h3478);
      exp_len_r  <= LEN_W'(2);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EXP_NAME: exp_name_r <= cfg_data;
        CFG_EXP_LEN:  exp_len_r  <= cfg_data[LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_take  = out_valid_r && out_tready;

  bts_scan_core #(.NAME_MAX(NAME_MAX)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_acc),
    .data_byte     (in_tdata),
    .expected_name (exp_name_r),
    .expected_len  (exp_len_r),
    .result        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      out_valid_r  <= skid_valid_r || in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (in_acc) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r.in_capture, out_data_r.mismatch};

endmodule

// File: bench/board_tag_stream_scanner_tb.sv
// Self-checking bench for board_tag_stream_scanner: drives image bytes and
// register writes, predicts every status transfer and checks it field by field.
// Depends on bts_pkg and the scanner RTL.
module board_tag_stream_scanner_tb;
  import bts_pkg::*;

  localparam int unsigned NAME_MAX    = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES = 480;
  localparam logic [NAME_W-1:0] RST_NAME = 64'h3478;
  localparam logic [LEN_W-1:0]  RST_LEN  = 4'd2;
  // tag magic, one character per entry
  localparam logic [7:0] TAG_MAGIC [MAGIC_CHARS] = '{
    8'h43, 8'h52, 8'h4F, 8'h53, 8'h53, 8'h50, 8'h4F, 8'h49, 8'h4E, 8'h54,
    8'h2D, 8'h42, 8'h4F, 8'h41, 8'h52, 8'h44, 8'h2D, 8'h56, 8'h31, 8'h3A
  };

  // Tracks the scan state and holds the status words still owed by the block.
  class tag_scoreboard;
    logic [NAME_W-1:0] want_name;
    logic [LEN_W-1:0]  want_len;
    int unsigned       mpos;
    int unsigned       count;
    bit                capturing;
    bit                flagged;
    logic [7:0]        store [NAME_MAX];
    bts_result_t       pending [$];
    int unsigned       errors;

    function new();
      want_name = RST_NAME;
      want_len  = RST_LEN;
      mpos      = 0;
      count     = 0;
      capturing = 0;
      flagged   = 0;
      errors    = 0;
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function void write_reg(logic idx, logic [NAME_W-1:0] v);
      if (idx == CFG_EXP_NAME) want_name = v;
      else want_len = v[LEN_W-1:0];
    endfunction

    function bit name_ok();
      if (count != want_len) return 0;
      for (int unsigned i = 0; i < count; i++)
        if (store[i] != want_name[8*i +: 8]) return 0;
      return 1;
    endfunction

    function void note_byte(logic [7:0] c);
      bts_result_t r;
      if (!flagged) begin
        if (capturing) begin
          if (c == TERM_BYTE) begin
            capturing = 0;
            if (!name_ok()) flagged = 1;
          end else if (count < NAME_MAX && c > PRINT_LOW && c < PRINT_HIGH) begin
            store[count] = c;
            count++;
          end else begin
            // abandoned capture; this byte is not fed to the magic search
            capturing = 0;
          end
        end else begin
          if (mpos >= MAGIC_CHARS) mpos = 0;
          if (c == TAG_MAGIC[mpos]) begin
            mpos++;
            if (mpos == MAGIC_CHARS) begin
              mpos      = 0;
              capturing = 1;
              count     = 0;
            end
          end else begin
            mpos = (c == TAG_MAGIC[0]) ? 1 : 0;
          end
        end
      end
      r.mismatch   = flagged;
      r.in_capture = capturing;
      pending.push_back(r);
    endfunction

    function void check(logic [7:0] got);
      bts_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: status transfer %h with nothing pending", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got[0] !== want.mismatch) begin
        errors++;
        $display("%0t: mismatch flag expected %b got %b", $time, want.mismatch, got[0]);
      end
      if (got[1] !== want.in_capture) begin
        errors++;
        $display("%0t: in_capture expected %b got %b", $time, want.in_capture, got[1]);
      end
      if (got[7:2] !== 6'b0) begin
        errors++;
        $display("%0t: pad bits expected 000000 got %b", $time, got[7:2]);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [NAME_W-1:0] cfg_data;

  tag_scoreboard     board;
  bit                steady;
  bit                hold_off_req;
  int unsigned       bytes_sent;
  int unsigned       quiet;
  logic [NAME_W-1:0] cur_name;
  int unsigned       cur_len;

  board_tag_stream_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // printable name character, never the terminator
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == TERM_BYTE);
    return c;
  endfunction

  function automatic logic [7:0] bad_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h00, 8'h20));
    return 8'($urandom_range(8'h7F, 8'hFF));
  endfunction

  // first k bytes printable, the rest arbitrary
  function automatic logic [NAME_W-1:0] make_name(int unsigned k);
    logic [NAME_W-1:0] nm;
    for (int unsigned i = 0; i < NAME_MAX; i++)
      nm[8*i +: 8] = (i < k) ? name_char() : 8'($urandom);
    return nm;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) board.note_byte(in_tdata);
      if (out_tvalid && out_tready) board.check(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
        (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    out_tready = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        stall_left   = HOLD_CYCLES;
        hold_off_req = 0;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_magic(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(TAG_MAGIC[i]);
  endtask

  task automatic send_name(input logic [NAME_W-1:0] nm, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(nm[8*i +: 8]);
  endtask

  task automatic send_tag();
    send_magic(MAGIC_CHARS);
    send_name(cur_name, (cur_len > NAME_MAX) ? NAME_MAX : cur_len);
    push_byte(TERM_BYTE);
  endtask

  // stop driving bytes and wait until every status word is back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [NAME_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_EXP_NAME) cur_name = v;
    else cur_len = v[LEN_W-1:0];
  endtask

  task automatic set_len(input int unsigned n);
    logic [NAME_W-1:0] v;
    v = {$urandom, $urandom};
    v[LEN_W-1:0] = n[LEN_W-1:0];
    set_reg(CFG_EXP_LEN, v);
  endtask

  // mostly well-formed tags, mixed with broken, overlong and random sequences
  task automatic run_traffic(input int unsigned n);
    int unsigned stop;
    int unsigned kind;
    int unsigned k;
    logic [7:0]  b;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_tag();
      end else if (kind < 55) begin
        send_magic(MAGIC_CHARS);
        k = $urandom_range(0, NAME_MAX);
        send_name(make_name(k), k);
        push_byte(bad_byte());
      end else if (kind < 65) begin
        // overlong name
        send_magic(MAGIC_CHARS);
        send_name(make_name(NAME_MAX), NAME_MAX);
        push_byte(name_char());
      end else if (kind < 80) begin
        // broken magic, often restarting on its first character
        k = $urandom_range(1, MAGIC_CHARS - 1);
        send_magic(k);
        do b = ($urandom_range(0, 3) == 0) ? TAG_MAGIC[0] : 8'($urandom);
        while (b == TAG_MAGIC[k]);
        push_byte(b);
      end else begin
        k = $urandom_range(1, 8);
        repeat (k) push_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_EXP_NAME;
    cfg_data     = '0;
    steady       = 0;
    hold_off_req = 0;
    bytes_sent   = 0;
    quiet        = 0;
    cur_name     = RST_NAME;
    cur_len      = RST_LEN;
    board        = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // byte extremes, a restart on the first magic character, then a tag
    // that matches the power-up name
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(TAG_MAGIC[0]);
    push_byte(TAG_MAGIC[1]);
    push_byte(TAG_MAGIC[0]);
    send_tag();

    // empty name expected; output held off long enough to back up the input
    set_reg(CFG_EXP_NAME, '1);
    set_len(0);
    hold_off_req = 1;
    run_traffic(PHASE_BYTES);

    // full-length name, no idling on either side
    set_reg(CFG_EXP_NAME, make_name(NAME_MAX));
    set_len(NAME_MAX);
    steady = 1;
    run_traffic(PHASE_BYTES);
    steady = 0;

    set_len($urandom_range(1, NAME_MAX - 1));
    set_reg(CFG_EXP_NAME, make_name(cur_len));
    run_traffic(PHASE_BYTES);

    set_len($urandom_range(0, NAME_MAX));
    set_reg(CFG_EXP_NAME, make_name(cur_len));
    run_traffic(PHASE_BYTES);

    // length above the name bound: the next tag trips the sticky flag and
    // everything after it is ignored
    set_reg(CFG_EXP_NAME, '0);
    set_len(4'hF);
    send_magic(MAGIC_CHARS);
    send_name(make_name(2), 2);
    push_byte(TERM_BYTE);
    run_traffic(60);

    settle();
    repeat (5) @(posedge clk);
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bts_pkg.sv
rtl/bts_scan_core.sv
rtl/board_tag_stream_scanner.sv
bench/board_tag_stream_scanner_tb.sv
